### hdl/two_queue_time_slice_scheduler_defines.svh
// assertion macros for the two-queue time-slice scheduler
`ifndef TWO_QUEUE_TIME_SLICE_SCHEDULER_DEFINES_SVH
`define TWO_QUEUE_TIME_SLICE_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TQS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TQS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tqs_pkg.sv
// shared types and constants of the two-queue time-slice scheduler
`timescale 1ns / 1ps
package tqs_pkg;

  localparam int MaxTasksDef     = 16;
  localparam int PriorityBitsDef = 8;
  localparam int TaskIdW         = 4;
  localparam int PriReqW         = 8;

  typedef enum logic [1:0] {
    OP_YIELD  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SET    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NONE    = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_CK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DROP_DONE,
    ST_SWITCH,
    ST_SRCH_RD,
    ST_SRCH_CK,
    ST_LOAD
  } state_e;

  // memory port control
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

### hdl/tqs_ram.sv
// single-port synchronous memory with registered read data
`timescale 1ns / 1ps
module tqs_ram
  import tqs_pkg::*;
#(
  parameter int Width = 4,
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  ram_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tqs_ctrl.sv
// scheduler sequencer: decode, queue scan, shift, push and runnable search
`timescale 1ns / 1ps
`include "two_queue_time_slice_scheduler_defines.svh"
module tqs_ctrl
  import tqs_pkg::*;
#(
  parameter int MaxTasks     = MaxTasksDef,
  parameter int PriorityBits = PriorityBitsDef,
  parameter int IdxW         = (MaxTasks > 1) ? $clog2(MaxTasks) : 1,
  parameter int LenW         = $clog2(MaxTasks + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation_i,
  input  logic [TaskIdW-1:0]      task_id_i,
  input  logic [PriReqW-1:0]      priority_req_i,
  input  logic                    runnable_i,
  output logic [TaskIdW-1:0]      run_task_o,
  output logic                    run_valid_o,
  output logic [1:0]              status_o,
  output logic                    done_o,
  output ram_ctl_t                q_ctl_o,
  output logic [IdxW:0]           q_addr_o,
  output logic [TaskIdW-1:0]      q_wdata_o,
  input  logic [TaskIdW-1:0]      q_rdata_i,
  output ram_ctl_t                p_ctl_o,
  output logic [IdxW-1:0]         p_addr_o,
  output logic [PriorityBits-1:0] p_wdata_o,
  input  logic [PriorityBits-1:0] p_rdata_i
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [TaskIdW-1:0]      tgt_q, tgt_d;
  logic                    qsel_q, qsel_d;
  logic                    act_q, act_d;
  logic                    second_q, second_d;
  logic [LenW-1:0]         i_q, i_d;
  logic [LenW-1:0]         len0_q, len0_d, len1_q, len1_d;
  logic [PriorityBits-1:0] slice_q, slice_d;
  logic [TaskIdW-1:0]      cur_q, cur_d;
  logic                    curv_q, curv_d;
  logic [MaxTasks-1:0]     present_q, present_d, runnable_q, runnable_d;
  logic                    done_q, done_d;
  logic [TaskIdW-1:0]      run_task_q, run_task_d;
  logic                    run_valid_q, run_valid_d;
  status_e                 status_q, status_d;

  logic                    accept;
  op_e                     op_in;
  logic                    id_ok;
  logic [IdxW-1:0]         id_idx;
  logic [PriorityBits-1:0] pri_in, pri_store;
  logic [LenW-1:0]         len_sel, len_act, len_oth, i_inc;
  logic                    fast_run, need_drop, rd_hit;
  logic [LenW-1:0]         max_len;

  // input decode
  assign accept    = start && !busy;
  assign op_in     = op_e'(operation_i);
  assign id_ok     = int'(task_id_i) < MaxTasks;
  assign id_idx    = IdxW'(task_id_i);
  assign pri_in    = PriorityBits'(priority_req_i);
  assign pri_store = (pri_in == '0) ? PriorityBits'(1) : pri_in;
  assign max_len   = LenW'(MaxTasks);

  // queue lengths and scan helpers
  assign len_sel  = qsel_q ? len1_q : len0_q;
  assign len_act  = act_q ? len1_q : len0_q;
  assign len_oth  = act_q ? len0_q : len1_q;
  assign i_inc    = i_q + LenW'(1);
  assign fast_run = curv_q && runnable_q[IdxW'(cur_q)] && (slice_q != '0);
  assign need_drop = curv_q && (slice_q == '0);
  assign rd_hit   = (int'(q_rdata_i) < MaxTasks) && runnable_q[IdxW'(q_rdata_i)];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_in == OP_YIELD) begin
            if (fast_run) begin
              state_d = ST_IDLE;
            end else if (need_drop) begin
              state_d = ST_DROP_RD;
            end else begin
              state_d = ST_SWITCH;
            end
          end else if (op_in == OP_REMOVE && id_ok && present_q[id_idx]) begin
            state_d = ST_DROP_RD;
          end
        end
      end
      ST_DROP_RD: begin
        if (i_q != len_sel) begin
          state_d = ST_DROP_CK;
        end else if (qsel_q) begin
          state_d = ST_DROP_DONE;
        end
      end
      ST_DROP_CK: begin
        state_d = (q_rdata_i == tgt_q) ? ST_SHIFT_RD : ST_DROP_RD;
      end
      ST_SHIFT_RD: begin
        if (i_inc < len_sel) begin
          state_d = ST_SHIFT_WR;
        end else begin
          state_d = qsel_q ? ST_DROP_DONE : ST_DROP_RD;
        end
      end
      ST_SHIFT_WR:  state_d = ST_SHIFT_RD;
      ST_DROP_DONE: state_d = (op_q == OP_YIELD) ? ST_SWITCH : ST_IDLE;
      ST_SWITCH:    state_d = ST_SRCH_RD;
      ST_SRCH_RD: begin
        if (i_q != len_act) begin
          state_d = ST_SRCH_CK;
        end else if (second_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_SRCH_CK: state_d = rd_hit ? ST_LOAD : ST_SRCH_RD;
      ST_LOAD:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    tgt_d       = tgt_q;
    qsel_d      = qsel_q;
    act_d       = act_q;
    second_d    = second_q;
    i_d         = i_q;
    len0_d      = len0_q;
    len1_d      = len1_q;
    slice_d     = slice_q;
    cur_d       = cur_q;
    curv_d      = curv_q;
    present_d   = present_q;
    runnable_d  = runnable_q;
    done_d      = 1'b0;
    run_task_d  = run_task_q;
    run_valid_d = run_valid_q;
    status_d    = status_q;
    q_ctl_o     = '0;
    q_addr_o    = {qsel_q, i_q[IdxW-1:0]};
    q_wdata_o   = tgt_q;
    p_ctl_o     = '0;
    p_addr_o    = id_idx;
    p_wdata_o   = pri_store;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d        = op_in;
          done_d      = 1'b1;
          run_task_d  = '0;
          run_valid_d = 1'b0;
          status_d    = STS_OK;
          if (op_in == OP_YIELD) begin
            if (fast_run) begin
              slice_d     = slice_q - PriorityBits'(1);
              run_task_d  = cur_q;
              run_valid_d = 1'b1;
            end else begin
              done_d = 1'b0;
              tgt_d  = cur_q;
              qsel_d = 1'b0;
              i_d    = '0;
            end
          end else if (!id_ok) begin
            status_d = STS_UNKNOWN;
          end else if (op_in == OP_ADD) begin
            if (present_q[id_idx] || (len0_q == max_len)) begin
              status_d = STS_FULL;
            end else begin
              // append to the tail of queue zero
              q_ctl_o.we          = 1'b1;
              q_addr_o            = {1'b0, len0_q[IdxW-1:0]};
              q_wdata_o           = task_id_i;
              p_ctl_o.we          = 1'b1;
              len0_d              = len0_q + LenW'(1);
              present_d[id_idx]   = 1'b1;
              runnable_d[id_idx]  = 1'b1;
            end
          end else if (!present_q[id_idx]) begin
            status_d = STS_UNKNOWN;
          end else if (op_in == OP_SET) begin
            runnable_d[id_idx] = runnable_i;
          end else begin
            done_d = 1'b0;
            tgt_d  = task_id_i;
            qsel_d = 1'b0;
            i_d    = '0;
          end
        end
      end
      // scan for the task to drop
      ST_DROP_RD: begin
        if (i_q != len_sel) begin
          q_ctl_o.re = 1'b1;
        end else if (!qsel_q) begin
          qsel_d = 1'b1;
          i_d    = '0;
        end
      end
      ST_DROP_CK: begin
        if (q_rdata_i != tgt_q) begin
          i_d = i_inc;
        end
      end
      // close the gap one entry a step
      ST_SHIFT_RD: begin
        if (i_inc < len_sel) begin
          q_ctl_o.re = 1'b1;
          q_addr_o   = {qsel_q, i_inc[IdxW-1:0]};
        end else begin
          if (qsel_q) begin
            len1_d = len1_q - LenW'(1);
          end else begin
            len0_d = len0_q - LenW'(1);
          end
          qsel_d = 1'b1;
          i_d    = '0;
        end
      end
      ST_SHIFT_WR: begin
        q_ctl_o.we = 1'b1;
        q_wdata_o  = q_rdata_i;
        i_d        = i_inc;
      end
      ST_DROP_DONE: begin
        if (op_q == OP_YIELD) begin
          // move the spent task to the tail of the other queue
          if (len_oth < max_len) begin
            q_ctl_o.we = 1'b1;
            q_addr_o   = {!act_q, len_oth[IdxW-1:0]};
            if (act_q) begin
              len0_d = len0_q + LenW'(1);
            end else begin
              len1_d = len1_q + LenW'(1);
            end
          end
        end else begin
          present_d[IdxW'(tgt_q)]  = 1'b0;
          runnable_d[IdxW'(tgt_q)] = 1'b0;
          if (curv_q && (cur_q == tgt_q)) begin
            curv_d  = 1'b0;
            slice_d = '0;
          end
          done_d      = 1'b1;
          run_task_d  = '0;
          run_valid_d = 1'b0;
          status_d    = STS_OK;
        end
      end
      ST_SWITCH: begin
        if (len_act == '0) begin
          act_d = !act_q;
        end
        i_d      = '0;
        second_d = 1'b0;
      end
      // search for the first runnable entry
      ST_SRCH_RD: begin
        q_addr_o = {act_q, i_q[IdxW-1:0]};
        if (i_q != len_act) begin
          q_ctl_o.re = 1'b1;
        end else if (!second_q) begin
          act_d    = !act_q;
          second_d = 1'b1;
          i_d      = '0;
        end else begin
          curv_d      = 1'b0;
          slice_d     = '0;
          done_d      = 1'b1;
          run_task_d  = '0;
          run_valid_d = 1'b0;
          status_d    = STS_NONE;
        end
      end
      ST_SRCH_CK: begin
        if (rd_hit) begin
          cur_d      = q_rdata_i;
          p_ctl_o.re = 1'b1;
          p_addr_o   = IdxW'(q_rdata_i);
        end else begin
          i_d = i_inc;
        end
      end
      ST_LOAD: begin
        slice_d     = p_rdata_i - PriorityBits'(1);
        curv_d      = 1'b1;
        done_d      = 1'b1;
        run_task_d  = cur_q;
        run_valid_d = 1'b1;
        status_d    = STS_OK;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_YIELD;
      qsel_q     <= 1'b0;
      act_q      <= 1'b0;
      second_q   <= 1'b0;
      i_q        <= '0;
      len0_q     <= '0;
      len1_q     <= '0;
      slice_q    <= '0;
      cur_q      <= '0;
      curv_q     <= 1'b0;
      present_q  <= '0;
      runnable_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      qsel_q     <= qsel_d;
      act_q      <= act_d;
      second_q   <= second_d;
      i_q        <= i_d;
      len0_q     <= len0_d;
      len1_q     <= len1_d;
      slice_q    <= slice_d;
      cur_q      <= cur_d;
      curv_q     <= curv_d;
      present_q  <= present_d;
      runnable_q <= runnable_d;
      done_q     <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    run_task_q  <= run_task_d;
    run_valid_q <= run_valid_d;
    status_q    <= status_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign run_task_o  = run_task_q;
  assign run_valid_o = run_valid_q;
  assign status_o    = status_q;

  `TQS_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accept, done_q || busy, "accepted item stalled")
  `TQS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy, "result while busy")
  `TQS_ASSERT_IMP(a_valid_ok, clk_i, rst_ni, done_q && run_valid_q, status_q == STS_OK, "run with error status")
  `TQS_ASSERT_IMP(a_len_total, clk_i, rst_ni, 1'b1, ({1'b0, len0_q} + {1'b0, len1_q}) <= (LenW + 1)'(MaxTasks), "queues over capacity")
  `TQS_ASSERT_IMP(a_cur_present, clk_i, rst_ni, curv_q, present_q[IdxW'(cur_q)], "current task absent")

endmodule

### hdl/two_queue_time_slice_scheduler.sv
// top level of the two-queue time-slice scheduler
//
//  channel  | ports                                        | transfer
//  ---------+----------------------------------------------+--------------------------
//  command  | operation_i task_id_i priority_req_i runnable_i | start high, busy low
//  result   | run_task_o run_valid_o status_o              | done_o high, one cycle
//
// add, set and rejected commands finish in the accept cycle; the result is registered
// and appears in the cycle after; a yield that keeps its slice is as fast; other commands
// scan the queues entry by entry through the single queue memory port (read, check, shift)
// reset clears lengths, task bits and the current task; the memories need no clearing
// the receiver cannot stall: busy alone holds off the next command
`timescale 1ns / 1ps
module two_queue_time_slice_scheduler
  import tqs_pkg::*;
#(
  parameter int MAX_TASKS     = MaxTasksDef,
  parameter int PRIORITY_BITS = PriorityBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [TaskIdW-1:0] task_id_i,
  input  logic [PriReqW-1:0] priority_req_i,
  input  logic               runnable_i,
  output logic [TaskIdW-1:0] run_task_o,
  output logic               run_valid_o,
  output logic [1:0]         status_o,
  output logic               done_o
);

  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LenW = $clog2(MAX_TASKS + 1);

  ram_ctl_t                 q_ctl, p_ctl;
  logic [IdxW:0]            q_addr;
  logic [TaskIdW-1:0]       q_wdata, q_rdata;
  logic [IdxW-1:0]          p_addr;
  logic [PRIORITY_BITS-1:0] p_wdata, p_rdata;

  // sequencer
  tqs_ctrl #(
    .MaxTasks    (MAX_TASKS),
    .PriorityBits(PRIORITY_BITS),
    .IdxW        (IdxW),
    .LenW        (LenW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .operation_i,
    .task_id_i,
    .priority_req_i,
    .runnable_i,
    .run_task_o,
    .run_valid_o,
    .status_o,
    .done_o,
    .q_ctl_o  (q_ctl),
    .q_addr_o (q_addr),
    .q_wdata_o(q_wdata),
    .q_rdata_i(q_rdata),
    .p_ctl_o  (p_ctl),
    .p_addr_o (p_addr),
    .p_wdata_o(p_wdata),
    .p_rdata_i(p_rdata)
  );

  // both task queues, selected by the top address bit
  tqs_ram #(
    .Width(TaskIdW),
    .Depth(2 * (1 << IdxW)),
    .AddrW(IdxW + 1)
  ) u_queue_ram (
    .clk_i,
    .ctl_i  (q_ctl),
    .addr_i (q_addr),
    .wdata_i(q_wdata),
    .rdata_o(q_rdata)
  );

  // slice length per task
  tqs_ram #(
    .Width(PRIORITY_BITS),
    .Depth(1 << IdxW),
    .AddrW(IdxW)
  ) u_pri_ram (
    .clk_i,
    .ctl_i  (p_ctl),
    .addr_i (p_addr),
    .wdata_i(p_wdata),
    .rdata_o(p_rdata)
  );

endmodule
